// ----- rtl/fpa_pkg.sv -----
// Package for the Q24.8 fixed-point ALU: widths, action codes, the pipeline
// record and the saturation helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 8;
   localparam int ACT_W     = 4;
   localparam int NUM_W     = DATA_W + FRAC_BITS;
   localparam int DIV_STEPS = NUM_W;
   localparam int PROD_W    = 2 * DATA_W;

   typedef enum logic [ACT_W-1:0] {
      ACT_ADD      = 4'd0,
      ACT_SUB      = 4'd1,
      ACT_MUL      = 4'd2,
      ACT_DIV      = 4'd3,
      ACT_MIN      = 4'd4,
      ACT_MAX      = 4'd5,
      ACT_INC      = 4'd6,
      ACT_DEC      = 4'd7,
      ACT_FROM_INT = 4'd8,
      ACT_TO_INT   = 4'd9
   } action_type;

   // Record that travels down the pipeline with each request.
   typedef struct packed {
      logic [ACT_W-1:0]         action;
      logic signed [DATA_W-1:0] simple_value;
      logic                     simple_sat;
      logic                     a_greater;
      logic                     a_less;
      logic                     operands_equal;
      logic                     divide_by_zero;
      logic signed [PROD_W-1:0] product;
      logic                     quot_neg;
      logic [DATA_W-1:0]        den;
      logic [DATA_W-1:0]        rem;
      logic [NUM_W-1:0]         numq;
   } pipe_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     sat;
   } sat_res_type;

   // Clamp a 33-bit signed sum into 32 bits.
   function automatic sat_res_type sat_sum(input logic signed [DATA_W:0] v);
      sat_res_type r;
      r.sat = (v[DATA_W] != v[DATA_W-1]);
      if (!r.sat) begin
         r.value = v[DATA_W-1:0];
      end else if (v[DATA_W]) begin
         r.value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r.value = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   // Apply a sign to an unsigned magnitude and clamp to 32 bits.
   function automatic sat_res_type sat_mag(input logic [PROD_W-1:0] m, input logic neg);
      sat_res_type r;
      logic [PROD_W-1:0] lim;
      lim = neg ? (PROD_W'(1) << (DATA_W-1)) : ((PROD_W'(1) << (DATA_W-1)) - PROD_W'(1));
      r.sat = (m > lim);
      if (r.sat) begin
         r.value = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else if (neg) begin
         r.value = DATA_W'(~m + PROD_W'(1));
      end else begin
         r.value = m[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/fpa_req_if.sv -----
// Request and response channel interfaces of the fixed-point ALU.
// Depends on fpa_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface fpa_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [fpa_pkg::ACT_W-1:0]                action;
   logic signed [fpa_pkg::DATA_W-1:0]        operand_a;
   logic signed [fpa_pkg::DATA_W-1:0]        operand_b;
   modport source (output valid, action, operand_a, operand_b, input ready);
   modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [fpa_pkg::DATA_W-1:0] result_value;
   logic                              a_greater;
   logic                              a_less;
   logic                              operands_equal;
   logic                              divide_by_zero;
   logic                              saturated;
   modport source (output valid, result_value, a_greater, a_less, operands_equal,
                   divide_by_zero, saturated, input ready);
   modport sink   (input valid, result_value, a_greater, a_less, operands_equal,
                   divide_by_zero, saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/fpa_front.sv -----
// First pipeline stage: compare flags, the simple actions, the product
// and the divider set-up. Depends on fpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fpa_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic                              in_valid,
   input  wire logic [fpa_pkg::ACT_W-1:0]         action,
   input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_a,
   input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_b,
   output logic                                   out_valid,
   output fpa_pkg::pipe_type                      out_stage
);
   localparam int DW = fpa_pkg::DATA_W;
   localparam int FB = fpa_pkg::FRAC_BITS;

   logic                      valid_ff, valid_in;
   fpa_pkg::pipe_type         stage_ff, stage_in;
   fpa_pkg::sat_res_type      add_r, sub_r, inc_r, dec_r;
   logic signed [DW+FB-1:0]   shifted;
   logic [FB:0]               top_bits;
   logic [DW-1:0]             mag_a, mag_b;

   // Saturating sums, the integer-to-fixed shift and the operand magnitudes.
   always_comb begin
      add_r    = fpa_pkg::sat_sum({operand_a[DW-1], operand_a} + {operand_b[DW-1], operand_b});
      sub_r    = fpa_pkg::sat_sum({operand_a[DW-1], operand_a} - {operand_b[DW-1], operand_b});
      inc_r    = fpa_pkg::sat_sum({operand_a[DW-1], operand_a} + (DW+1)'(1));
      dec_r    = fpa_pkg::sat_sum({operand_a[DW-1], operand_a} - (DW+1)'(1));
      shifted  = {operand_a, {FB{1'b0}}};
      top_bits = shifted[DW+FB-1:DW-1];
      mag_a    = operand_a[DW-1] ? (~operand_a + DW'(1)) : operand_a;
      mag_b    = operand_b[DW-1] ? (~operand_b + DW'(1)) : operand_b;
   end

   // Action decode for the results that finish here.
   always_comb begin
      stage_in                = '0;
      stage_in.action         = action;
      stage_in.a_greater      = operand_a > operand_b;
      stage_in.a_less         = operand_a < operand_b;
      stage_in.operands_equal = operand_a == operand_b;
      stage_in.product        = operand_a * operand_b;
      stage_in.quot_neg       = operand_a[DW-1] ^ operand_b[DW-1];
      stage_in.den            = mag_b;
      stage_in.numq           = {mag_a, {FB{1'b0}}};
      unique case (action)
         fpa_pkg::ACT_ADD: begin
            stage_in.simple_value = add_r.value;
            stage_in.simple_sat   = add_r.sat;
         end
         fpa_pkg::ACT_SUB: begin
            stage_in.simple_value = sub_r.value;
            stage_in.simple_sat   = sub_r.sat;
         end
         fpa_pkg::ACT_INC: begin
            stage_in.simple_value = inc_r.value;
            stage_in.simple_sat   = inc_r.sat;
         end
         fpa_pkg::ACT_DEC: begin
            stage_in.simple_value = dec_r.value;
            stage_in.simple_sat   = dec_r.sat;
         end
         fpa_pkg::ACT_MIN: begin
            stage_in.simple_value = (operand_a < operand_b) ? operand_a : operand_b;
         end
         fpa_pkg::ACT_MAX: begin
            stage_in.simple_value = (operand_a > operand_b) ? operand_a : operand_b;
         end
         fpa_pkg::ACT_DIV: begin
            stage_in.divide_by_zero = (operand_b == '0);
         end
         fpa_pkg::ACT_FROM_INT: begin
            stage_in.simple_sat = !((&top_bits) || !(|top_bits));
            if (!stage_in.simple_sat) begin
               stage_in.simple_value = shifted[DW-1:0];
            end else if (operand_a[DW-1]) begin
               stage_in.simple_value = {1'b1, {(DW-1){1'b0}}};
            end else begin
               stage_in.simple_value = {1'b0, {(DW-1){1'b1}}};
            end
         end
         fpa_pkg::ACT_TO_INT: begin
            stage_in.simple_value = operand_a >>> FB;
         end
         default: begin
            stage_in.simple_value = '0;
         end
      endcase
      valid_in = in_valid;
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;
endmodule
`default_nettype wire

// ----- rtl/fpa_div.sv -----
// Restoring divider pipeline, one quotient bit per stage, carrying the whole
// request record. Depends on fpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fpa_div (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  fpa_pkg::pipe_type      in_stage,
   output logic                   out_valid,
   output fpa_pkg::pipe_type      out_stage
);
   localparam int N  = fpa_pkg::DIV_STEPS;
   localparam int DW = fpa_pkg::DATA_W;
   localparam int NW = fpa_pkg::NUM_W;

   logic              valid_ff [N];
   fpa_pkg::pipe_type stage_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_step
      logic              prev_valid;
      fpa_pkg::pipe_type prev, step_in;
      logic [DW:0]       trial;
      logic              fits;

      if (i == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev       = in_stage;
      end else begin : g_rest
         assign prev_valid = valid_ff[i-1];
         assign prev       = stage_ff[i-1];
      end

      // Shift in the next dividend bit and subtract where the divisor fits.
      always_comb begin
         step_in      = prev;
         trial        = {prev.rem, prev.numq[NW-1]};
         fits         = trial >= {1'b0, prev.den};
         step_in.rem  = fits ? DW'(trial - {1'b0, prev.den}) : trial[DW-1:0];
         step_in.numq = {prev.numq[NW-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= prev_valid;
         end
         if (advance) begin
            stage_ff[i] <= step_in;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_stage = stage_ff[N-1];
endmodule
`default_nettype wire

// ----- rtl/fpa_back.sv -----
// Last stage: rounding and saturation of product and quotient, result
// selection and the output register. Depends on fpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fpa_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic                       in_valid,
   input  fpa_pkg::pipe_type               in_stage,
   output logic                            out_valid,
   output logic signed [fpa_pkg::DATA_W-1:0] result_value,
   output logic                            a_greater,
   output logic                            a_less,
   output logic                            operands_equal,
   output logic                            divide_by_zero,
   output logic                            saturated
);
   localparam int DW = fpa_pkg::DATA_W;
   localparam int FB = fpa_pkg::FRAC_BITS;
   localparam int PW = fpa_pkg::PROD_W;

   logic [PW-1:0]          prod_mag, mul_q, div_q;
   logic                   round_up;
   fpa_pkg::sat_res_type   mul_r, div_r;
   logic                   valid_ff;
   logic signed [DW-1:0]   value_ff, value_in;
   logic                   sat_ff, sat_in;
   logic                   gt_ff, lt_ff, eq_ff, dz_ff;

   // Round half away from zero on magnitudes, then clamp.
   always_comb begin
      prod_mag = in_stage.product[PW-1] ? (~in_stage.product + PW'(1)) : in_stage.product;
      mul_q    = (prod_mag + (PW'(1) << (FB-1))) >> FB;
      mul_r    = fpa_pkg::sat_mag(mul_q, in_stage.product[PW-1]);
      round_up = {in_stage.rem, 1'b0} >= {1'b0, in_stage.den};
      div_q    = PW'(in_stage.numq) + PW'(round_up);
      div_r    = fpa_pkg::sat_mag(div_q, in_stage.quot_neg);
   end

   // Result selection.
   always_comb begin
      unique case (in_stage.action)
         fpa_pkg::ACT_MUL: begin
            value_in = mul_r.value;
            sat_in   = mul_r.sat;
         end
         fpa_pkg::ACT_DIV: begin
            value_in = in_stage.divide_by_zero ? '0 : div_r.value;
            sat_in   = !in_stage.divide_by_zero && div_r.sat;
         end
         default: begin
            value_in = in_stage.simple_value;
            sat_in   = in_stage.simple_sat;
         end
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         value_ff <= value_in;
         sat_ff   <= sat_in;
         gt_ff    <= in_stage.a_greater;
         lt_ff    <= in_stage.a_less;
         eq_ff    <= in_stage.operands_equal;
         dz_ff    <= in_stage.divide_by_zero;
      end
   end

   assign out_valid      = valid_ff;
   assign result_value   = value_ff;
   assign saturated      = sat_ff;
   assign a_greater      = gt_ff;
   assign a_less         = lt_ff;
   assign operands_equal = eq_ff;
   assign divide_by_zero = dz_ff;
endmodule
`default_nettype wire

// ----- rtl/fixed_point_alu_q24_8.sv -----
// Top level of the signed Q24.8 fixed-point ALU.
// Depends on fpa_pkg, fpa_req_if, fpa_front, fpa_div and fpa_back.
//
//   Channel | Direction | Contents
//   req_ch  | in        | action, operand_a, operand_b
//   rsp_ch  | out       | result_value, compare flags, divide_by_zero, saturated
//
// One request is taken per cycle unless the output stalls; each request passes
// through one front stage, one stage per quotient bit of the 40-bit dividend
// and one rounding and output stage. Reset empties the pipeline at once.
// When a result waits unread, the whole pipeline holds and req_ch.ready
// falls; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu_q24_8 (
   input  wire logic  clock,
   input  wire logic  reset,
   fpa_req_if.sink    req_ch,
   fpa_rsp_if.source  rsp_ch
);
   logic              advance;
   logic              front_valid, div_valid;
   fpa_pkg::pipe_type front_stage, div_stage;

   // The pipeline moves whenever the output register is free or being read.
   assign advance      = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = advance;

   fpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_ch.valid),
      .action    (req_ch.action),
      .operand_a (req_ch.operand_a),
      .operand_b (req_ch.operand_b),
      .out_valid (front_valid),
      .out_stage (front_stage)
   );

   fpa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_stage  (front_stage),
      .out_valid (div_valid),
      .out_stage (div_stage)
   );

   fpa_back u_back (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .in_valid       (div_valid),
      .in_stage       (div_stage),
      .out_valid      (rsp_ch.valid),
      .result_value   (rsp_ch.result_value),
      .a_greater      (rsp_ch.a_greater),
      .a_less         (rsp_ch.a_less),
      .operands_equal (rsp_ch.operands_equal),
      .divide_by_zero (rsp_ch.divide_by_zero),
      .saturated      (rsp_ch.saturated)
   );
endmodule
`default_nettype wire

// ----- rtl/fpa_chk.sv -----
// Port-level checker for the fixed-point ALU, bound to the top level.
// Depends on fixed_point_alu_q24_8.
`timescale 1ns / 1ps
`default_nettype none
module fpa_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] result_value,
   input wire logic        a_greater,
   input wire logic        a_less,
   input wire logic        operands_equal,
   input wire logic        divide_by_zero,
   input wire logic        saturated
);
   // Exactly one compare outcome holds.
   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({a_greater, a_less, operands_equal}))
      else $error("compare flags not one-hot");

   // Division by zero gives zero and no saturation.
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && divide_by_zero |-> result_value == 32'd0 && !saturated)
      else $error("divide by zero result wrong");

   // A saturated result sits on one of the bounds.
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && saturated |->
         result_value == 32'h7fff_ffff || result_value == 32'h8000_0000)
      else $error("saturated result off bound");

   // A stalled response holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_value))
      else $error("stalled response changed");
endmodule

bind fixed_point_alu_q24_8 fpa_chk u_fpa_chk (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .result_value   (rsp_ch.result_value),
   .a_greater      (rsp_ch.a_greater),
   .a_less         (rsp_ch.a_less),
   .operands_equal (rsp_ch.operands_equal),
   .divide_by_zero (rsp_ch.divide_by_zero),
   .saturated      (rsp_ch.saturated)
);
`default_nettype wire
